// File: hw/rtl/pft_pkg.sv
// Shared constants and types of the point frustum test block.
`default_nettype none

package pft_pkg;

   // Field and register widths.
   localparam int COORD_W   = 32;
   localparam int COEF_W    = 32;
   localparam int CFG_W     = 64;
   localparam int SIZE_W    = 13;
   localparam int CSR_IDX_W = 4;

   // Matrix shape: three rows, three point coefficients plus one offset per row.
   localparam int ROWS      = 3;
   localparam int COLS      = 3;
   localparam int PROJ_REGS = 2 * ROWS;

   // One Q16.16 by Q16.16 product is exact in 64 bits, Q32.32.
   localparam int PROD_W  = 2 * COEF_W;
   // Three products plus the shifted offset stay below 2^64 in magnitude.
   localparam int ROW_W   = PROD_W + 1;
   // Magnitude of a non-negative row sum.
   localparam int MAG_W   = ROW_W - 1;
   // Depth times an image size.
   localparam int BOUND_W = MAG_W + SIZE_W;
   // Offsets are aligned to Q32.32 by this shift.
   localparam int FRAC_W  = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_PROJ_ROW0_A  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_PROJ_ROW0_B  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_PROJ_ROW1_A  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_PROJ_ROW1_B  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_PROJ_ROW2_A  = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_PROJ_ROW2_B  = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(7);

   // Reset values of the image size registers.
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

   // Smallest raw Q32.32 depth that is at least 0.01.
   localparam logic [MAG_W-1:0] DEPTH_MIN = MAG_W'(42949673);

   // Queue between the front and the back.
   localparam int Q_DEPTH = 8;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [PROJ_REGS-1:0][CFG_W-1:0] proj;
      logic [SIZE_W-1:0]               image_width;
      logic [SIZE_W-1:0]               image_height;
   } cfg_type;

   // One classified item: the three row sums and the depth verdict.
   typedef struct packed {
      logic             depth_ok;
      logic [ROW_W-1:0] depth;
      logic [ROW_W-1:0] num_u;
      logic [ROW_W-1:0] num_v;
   } entry_type;

   // An entry together with its valid flag, used on both sides of the queue.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

endpackage

`default_nettype wire

// File: hw/rtl/pft_if.sv
// Handshake channels of the point frustum test block.
`default_nettype none

// Point channel.
interface pft_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [pft_pkg::COORD_W-1:0] point_x;
   logic signed [pft_pkg::COORD_W-1:0] point_y;
   logic signed [pft_pkg::COORD_W-1:0] point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface

// Result channel.
interface pft_rsp_if;
   logic valid;
   logic ready;
   logic in_view;

   modport source (output valid, output in_view, input ready);
   modport sink   (input valid, input in_view, output ready);
endinterface

// Register write channel.
interface pft_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pft_pkg::CSR_IDX_W-1:0]     index;
   logic [pft_pkg::CFG_W-1:0]         data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/point_frustum_test.sv
// Throughput: one point per cycle while a queue slot can be reserved; the front
// pipeline is two register stages deep and an 8-entry queue feeds a two-stage back,
// so up to 10 items are in the block at once. The back stalls on the result channel
// and the front keeps filling the queue.
// Synchronous reset empties the pipeline and queue, zeroes the projection matrix and
// sets the image size to 640 by 480.
`default_nettype none

module point_frustum_test (
   input  logic     clock,
   input  logic     reset,
   pft_req_if.sink  req_bus,
   pft_rsp_if.source rsp_bus,
   pft_csr_if.sink  csr_bus
);

   pft_pkg::cfg_type  cfg;
   pft_pkg::slot_type push;
   pft_pkg::slot_type head;
   logic              pop;

   // Configuration registers.
   pft_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   // Row sums and depth classification.
   pft_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .cfg   (cfg),
      .pop   (pop),
      .push  (push)
   );

   // Decoupling queue.
   pft_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head)
   );

   // Image bound checks and result register.
   pft_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .cfg   (cfg),
      .pop   (pop),
      .rsp   (rsp_bus)
   );

endmodule

`default_nettype wire

// File: hw/rtl/pft_csr.sv
// Configuration registers: projection matrix and image size.
`default_nettype none

module pft_csr (
   input  logic             clock,
   input  logic             reset,
   pft_csr_if.sink          csr,
   output pft_pkg::cfg_type cfg
);

   pft_pkg::cfg_type cfg_ff;
   pft_pkg::cfg_type cfg_in;

   // Writes are taken every cycle.
   assign csr.ready = 1'b1;

   // Register decode; indexes past the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            pft_pkg::REG_PROJ_ROW0_A:  cfg_in.proj[0] = csr.data;
            pft_pkg::REG_PROJ_ROW0_B:  cfg_in.proj[1] = csr.data;
            pft_pkg::REG_PROJ_ROW1_A:  cfg_in.proj[2] = csr.data;
            pft_pkg::REG_PROJ_ROW1_B:  cfg_in.proj[3] = csr.data;
            pft_pkg::REG_PROJ_ROW2_A:  cfg_in.proj[4] = csr.data;
            pft_pkg::REG_PROJ_ROW2_B:  cfg_in.proj[5] = csr.data;
            pft_pkg::REG_IMAGE_WIDTH:  cfg_in.image_width  = csr.data[pft_pkg::SIZE_W-1:0];
            pft_pkg::REG_IMAGE_HEIGHT: cfg_in.image_height = csr.data[pft_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.proj         <= '0;
         cfg_ff.image_width  <= pft_pkg::WIDTH_RESET;
         cfg_ff.image_height <= pft_pkg::HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pft_front.sv
// Front part: accepts points, forms the three row sums and classifies depth.
`default_nettype none

module pft_front (
   input  logic              clock,
   input  logic              reset,
   pft_req_if.sink           req,
   input  pft_pkg::cfg_type  cfg,
   input  logic              pop,
   output pft_pkg::slot_type push
);

   logic accept;

   // Items accepted and not yet taken out of the queue by the back.
   logic [pft_pkg::Q_CNT_W-1:0] occ_ff;
   logic [pft_pkg::Q_CNT_W-1:0] occ_in;

   // Stage one: nine products and the three offsets.
   logic                                                   s1_valid_ff;
   logic [pft_pkg::ROWS-1:0][pft_pkg::COLS-1:0][pft_pkg::PROD_W-1:0] s1_prod_ff;
   logic [pft_pkg::ROWS-1:0][pft_pkg::COLS-1:0][pft_pkg::PROD_W-1:0] s1_prod_in;
   logic [pft_pkg::ROWS-1:0][pft_pkg::COEF_W-1:0]         s1_off_ff;
   logic [pft_pkg::ROWS-1:0][pft_pkg::COEF_W-1:0]         s1_off_in;

   // Stage two: two partial sums per row.
   logic                                                   s2_valid_ff;
   logic [pft_pkg::ROWS-1:0][pft_pkg::ROW_W-1:0]          s2_lo_ff;
   logic [pft_pkg::ROWS-1:0][pft_pkg::ROW_W-1:0]          s2_lo_in;
   logic [pft_pkg::ROWS-1:0][pft_pkg::ROW_W-1:0]          s2_hi_ff;
   logic [pft_pkg::ROWS-1:0][pft_pkg::ROW_W-1:0]          s2_hi_in;

   logic [pft_pkg::ROWS-1:0][pft_pkg::ROW_W-1:0]          row_sum;
   logic [pft_pkg::COLS-1:0][pft_pkg::COORD_W-1:0]        point;

   // An item may enter only while it has a queue slot reserved.
   assign req.ready = (occ_ff < pft_pkg::Q_CNT_W'(pft_pkg::Q_DEPTH));
   assign accept    = req.valid && req.ready;

   assign point[0] = req.point_x;
   assign point[1] = req.point_y;
   assign point[2] = req.point_z;

   // One signed multiplier per matrix coefficient.
   for (genvar r = 0; r < pft_pkg::ROWS; r++) begin : g_row
      for (genvar c = 0; c < pft_pkg::COLS; c++) begin : g_col
         logic signed [pft_pkg::COEF_W-1:0]  coef;
         logic signed [pft_pkg::COORD_W-1:0] coord;
         logic signed [pft_pkg::PROD_W-1:0]  prod;

         assign coef  = cfg.proj[2*r + c/2][pft_pkg::COEF_W*(c%2) +: pft_pkg::COEF_W];
         assign coord = point[c];
         assign prod  = coef * coord;
         assign s1_prod_in[r][c] = prod;
      end

      // The offset sits in the upper half of the second register of the row.
      assign s1_off_in[r] = cfg.proj[2*r + 1][pft_pkg::CFG_W-1 -: pft_pkg::COEF_W];

      // Partial sums, sign extended to the row width.
      assign s2_lo_in[r] = {s1_prod_ff[r][0][pft_pkg::PROD_W-1], s1_prod_ff[r][0]}
                         + {s1_prod_ff[r][1][pft_pkg::PROD_W-1], s1_prod_ff[r][1]};
      assign s2_hi_in[r] = {s1_prod_ff[r][2][pft_pkg::PROD_W-1], s1_prod_ff[r][2]}
                         + {{(pft_pkg::ROW_W - pft_pkg::COEF_W - pft_pkg::FRAC_W)
                             {s1_off_ff[r][pft_pkg::COEF_W-1]}},
                            s1_off_ff[r], {pft_pkg::FRAC_W{1'b0}}};

      assign row_sum[r] = s2_lo_ff[r] + s2_hi_ff[r];
   end

   // Classify the item and hand it to the queue.
   always_comb begin
      push.valid          = s2_valid_ff;
      push.entry.depth    = row_sum[2];
      push.entry.num_u    = row_sum[0];
      push.entry.num_v    = row_sum[1];
      push.entry.depth_ok = !row_sum[2][pft_pkg::ROW_W-1]
                         && (row_sum[2][pft_pkg::MAG_W-1:0] >= pft_pkg::DEPTH_MIN);
   end

   // Reservation count.
   always_comb begin
      occ_in = occ_ff;
      if (accept && !pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (!accept && pop) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         occ_ff      <= occ_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Datapath registers; the pipeline never stalls.
   always_ff @(posedge clock) begin
      s1_prod_ff <= s1_prod_in;
      s1_off_ff  <= s1_off_in;
      s2_lo_ff   <= s2_lo_in;
      s2_hi_ff   <= s2_hi_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/pft_queue.sv
// Short queue of classified items between the front and the back.
`default_nettype none

module pft_queue (
   input  logic              clock,
   input  logic              reset,
   input  pft_pkg::slot_type push,
   input  logic              pop,
   output pft_pkg::slot_type head
);

   pft_pkg::entry_type mem_ff [pft_pkg::Q_DEPTH];

   logic [pft_pkg::Q_PTR_W-1:0] wr_ptr_ff;
   logic [pft_pkg::Q_PTR_W-1:0] wr_ptr_in;
   logic [pft_pkg::Q_PTR_W-1:0] rd_ptr_ff;
   logic [pft_pkg::Q_PTR_W-1:0] rd_ptr_in;
   logic [pft_pkg::Q_CNT_W-1:0] cnt_ff;
   logic [pft_pkg::Q_CNT_W-1:0] cnt_in;

   // Oldest entry is always presented.
   assign head.valid = (cnt_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == pft_pkg::Q_PTR_W'(pft_pkg::Q_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == pft_pkg::Q_PTR_W'(pft_pkg::Q_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push.valid && pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

`ifndef SYNTH
   // The front's reservations must keep the queue from overflowing.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (cnt_ff < pft_pkg::Q_CNT_W'(pft_pkg::Q_DEPTH)))
      else $error("queue written while full");

   // The back only takes an entry that is there.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue read while empty");

   // A waiting head entry is not disturbed by writes behind it.
   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      head.valid && !pop |=> head.valid && (head.entry == $past(head.entry)))
      else $error("queue head changed without a read");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/pft_back.sv
// Back part: checks u and v against the image bounds and holds the result item.
`default_nettype none

module pft_back (
   input  logic              clock,
   input  logic              reset,
   input  pft_pkg::slot_type head,
   input  pft_pkg::cfg_type  cfg,
   output logic              pop,
   pft_rsp_if.source         rsp
);

   logic out_adv;
   logic b1_load;
   logic u_ok;
   logic v_ok;

   // Stage one: depth scaled by the image sizes.
   logic                          b1_valid_ff;
   logic                          b1_valid_in;
   logic                          b1_ok_ff;
   logic [pft_pkg::ROW_W-1:0]     b1_nu_ff;
   logic [pft_pkg::ROW_W-1:0]     b1_nv_ff;
   logic [pft_pkg::BOUND_W-1:0]   b1_bu_ff;
   logic [pft_pkg::BOUND_W-1:0]   b1_bu_in;
   logic [pft_pkg::BOUND_W-1:0]   b1_bv_ff;
   logic [pft_pkg::BOUND_W-1:0]   b1_bv_in;

   // Output register.
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic in_view_ff;
   logic in_view_in;

   // Advance whenever the next register is free or being emptied.
   assign out_adv = !rsp_valid_ff || rsp.ready;
   assign b1_load = !b1_valid_ff || out_adv;
   assign pop     = head.valid && b1_load;

   // Cross-multiplied bounds: u < width is nu < depth * width for positive depth.
   assign b1_bu_in = head.entry.depth[pft_pkg::MAG_W-1:0] * cfg.image_width;
   assign b1_bv_in = head.entry.depth[pft_pkg::MAG_W-1:0] * cfg.image_height;

   // Both numerators must be non-negative and below their bounds.
   assign u_ok = !b1_nu_ff[pft_pkg::ROW_W-1]
              && ({{pft_pkg::SIZE_W{1'b0}}, b1_nu_ff[pft_pkg::MAG_W-1:0]} < b1_bu_ff);
   assign v_ok = !b1_nv_ff[pft_pkg::ROW_W-1]
              && ({{pft_pkg::SIZE_W{1'b0}}, b1_nv_ff[pft_pkg::MAG_W-1:0]} < b1_bv_ff);

   assign b1_valid_in  = b1_load ? head.valid : b1_valid_ff;
   assign rsp_valid_in = out_adv ? b1_valid_ff : rsp_valid_ff;
   assign in_view_in   = b1_ok_ff && u_ok && v_ok;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         b1_ok_ff <= head.entry.depth_ok;
         b1_nu_ff <= head.entry.num_u;
         b1_nv_ff <= head.entry.num_v;
         b1_bu_ff <= b1_bu_in;
         b1_bv_ff <= b1_bv_in;
      end
      if (out_adv && b1_valid_ff) begin
         in_view_ff <= in_view_in;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.in_view = in_view_ff;

endmodule

`default_nettype wire
